// ===== rtl/core/antialiased_dot_pixel_blender_top_macros.svh =====
// Assertion macros shared by the blender RTL.
`ifndef ANTIALIASED_DOT_PIXEL_BLENDER_TOP_MACROS_SVH
`define ANTIALIASED_DOT_PIXEL_BLENDER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// Checked only while out of reset.
`define ADPB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define ADPB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ADPB_ASSERT(lbl, prop, msg)
`define ADPB_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/core/adpb_pkg.sv =====
package adpb_pkg;

  // Default coordinate width.
  localparam int COORD_WIDTH_DEF = 10;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_RADIUS      = 3'd2,
    REG_FILL_RED    = 3'd3,
    REG_FILL_GREEN  = 3'd4,
    REG_FILL_BLUE   = 3'd5,
    REG_CANVAS_SIZE = 3'd6
  } cfg_reg_t;

  // Reset values of the configuration registers.
  localparam int RADIUS_RESET = 6;
  localparam int CANVAS_RESET = 64;

  // The feather slope 255/1.2 per pixel equals 425/512 per Q.8 step.
  localparam logic [8:0] FILL_GAIN = 9'd425;
  localparam int FILL_SHIFT = 9;
  // Peak ring alpha.
  localparam logic [7:0] RING_PEAK = 8'd150;
  // Square scale so that the root is the pixel distance with 8 fraction bits.
  localparam int RAD_SHIFT = 14;

  // Queue status seen by the back end.
  typedef struct packed {
    logic full;
    logic empty;
  } adpb_qstat_t;

  // Exact floor(v/255) for v below 65280, where the result fits in 8 bits.
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] t;
    t = {1'b0, v} + 17'd1 + {9'd0, v[15:8]};
    return t[15:8];
  endfunction

endpackage

// ===== rtl/core/adpb_if.sv =====
// Valid/ready channel for canvas pixels going in.
interface adpb_in_if #(
  parameter int CW = adpb_pkg::COORD_WIDTH_DEF
);
  logic          valid;
  logic          ready;
  logic [CW-1:0] pixel_x;
  logic [CW-1:0] pixel_y;
  logic [7:0]    dst_red;
  logic [7:0]    dst_green;
  logic [7:0]    dst_blue;
  logic [7:0]    dst_alpha;

  modport source (output valid, pixel_x, pixel_y, dst_red, dst_green, dst_blue,
                  dst_alpha, input ready);
  modport sink (input valid, pixel_x, pixel_y, dst_red, dst_green, dst_blue,
                dst_alpha, output ready);
endinterface

// Valid/ready channel for composited pixels going out.
interface adpb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;

  modport source (output valid, out_red, out_green, out_blue, out_alpha,
                  input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_alpha,
                output ready);
endinterface

// ===== rtl/core/adpb_front.sv =====
// Classifies a pixel against canvas and box and forms its half-pixel offsets.
module adpb_front #(
  parameter int CW = adpb_pkg::COORD_WIDTH_DEF,
  parameter int EW = 2 * (CW + 1) + 33
) (
  input  logic [CW-1:0] px,
  input  logic [CW-1:0] py,
  input  logic [31:0]   rgba,
  input  logic [CW-1:0] center_x,
  input  logic [CW-1:0] center_y,
  input  logic [CW-2:0] radius,
  input  logic [CW:0]   canvas_size,
  output logic [EW-1:0] entry
);
  logic signed [CW+1:0] ex, ey, lim, ox, oy;
  logic [CW+1:0]        ax, ay;
  logic                 in_canvas, in_box;

  // Signed offsets from the center and the box half-width.
  assign ex  = $signed({2'b00, px}) - $signed({2'b00, center_x});
  assign ey  = $signed({2'b00, py}) - $signed({2'b00, center_y});
  assign lim = $signed({3'b000, radius}) + 'sd2;

  assign in_canvas = ({1'b0, px} < canvas_size) && ({1'b0, py} < canvas_size);
  assign in_box    = (ex <= lim) && (ex >= -lim) && (ey <= lim) && (ey >= -lim);

  // Offsets in half pixels, kept as magnitudes since only squares are used.
  assign ox = (ex <<< 1) + 'sd1;
  assign oy = (ey <<< 1) + 'sd1;
  assign ax = ox[CW+1] ? $unsigned(-ox) : $unsigned(ox);
  assign ay = oy[CW+1] ? $unsigned(-oy) : $unsigned(oy);

  assign entry = {in_canvas && in_box, ax[CW:0], ay[CW:0], rgba};
endmodule

// ===== rtl/core/adpb_queue.sv =====
// Small FIFO that decouples the front end from the back pipeline.
module adpb_queue #(
  parameter int EW    = 8,
  parameter int DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [EW-1:0]         wdata,
  input  logic                  pop,
  output logic [EW-1:0]         rdata,
  output adpb_pkg::adpb_qstat_t stat
);
  localparam int AW = $clog2(DEPTH);

  logic [EW-1:0] mem [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == (AW+1)'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign rdata      = mem[rp_r];

  // Pointer and fill-level update.
  always_comb begin
    wp_nxt  = push ? ((wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1) : wp_r;
    rp_nxt  = pop ? ((rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= wdata;
    end
  end
endmodule

// ===== rtl/core/adpb_isqrt.sv =====
// Pipelined restoring square root, one result bit per stage.
module adpb_isqrt #(
  parameter int QW  = 19,
  parameter int SBW = 33
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  logic [2*QW-1:0] radicand,
  input  logic [SBW-1:0] in_sb,
  output logic           out_valid,
  output logic [QW-1:0]  root,
  output logic [SBW-1:0] out_sb
);
  logic [2*QW-1:0] rad_r  [QW+1];
  logic [QW+1:0]   rem_r  [QW+1];
  logic [QW-1:0]   root_r [QW+1];
  logic [SBW-1:0]  sb_r   [QW+1];
  logic            vld_r  [QW+1];

  assign rad_r[0]  = radicand;
  assign rem_r[0]  = '0;
  assign root_r[0] = '0;
  assign sb_r[0]   = in_sb;
  assign vld_r[0]  = in_valid;

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [QW+1:0] rem_in, trial;
    logic          take;

    // Bring down the next bit pair and try the next root bit.
    assign rem_in = {rem_r[i][QW-1:0], rad_r[i][2*QW-1:2*QW-2]};
    assign trial  = {root_r[i], 2'b01};
    assign take   = (rem_in >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[i+1]  <= {rad_r[i][2*QW-3:0], 2'b00};
        rem_r[i+1]  <= take ? rem_in - trial : rem_in;
        root_r[i+1] <= {root_r[i][QW-2:0], take};
        sb_r[i+1]   <= sb_r[i];
      end
    end
  end

  assign out_valid = vld_r[QW];
  assign root      = root_r[QW];
  assign out_sb    = sb_r[QW];
endmodule

// ===== rtl/core/adpb_back.sv =====
// Back pipeline: distance, layer alphas, fill blend, ring blend, output register.
module adpb_back #(
  parameter int CW = adpb_pkg::COORD_WIDTH_DEF,
  parameter int EW = 2 * (CW + 1) + 33
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  adpb_pkg::adpb_qstat_t qstat,
  input  logic [EW-1:0]         entry,
  output logic                  pop,
  input  logic [CW-2:0]         radius,
  input  logic [7:0]            fill_red,
  input  logic [7:0]            fill_green,
  input  logic [7:0]            fill_blue,
  adpb_out_if.source            out_ch
);
  localparam int SQW = 2 * CW + 3;
  localparam int QW  = CW + 9;
  localparam int RQW = CW + 7;
  localparam int SBW = 33;

  logic en;

  // The whole pipeline moves unless a finished pixel is still waiting.
  assign en  = !out_ch.valid || out_ch.ready;
  assign pop = en && !qstat.empty;

  // Squares of the offset magnitudes.
  logic            s1_vld_r;
  logic [2*CW+1:0] s1_sqx_r, s1_sqy_r;
  logic [SBW-1:0]  s1_sb_r;
  logic [CW:0]     ax, ay;

  assign ax = entry[32 + 2*(CW+1) - 1 : 32 + CW + 1];
  assign ay = entry[32 + CW : 32];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= !qstat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sqx_r <= (2*CW+2)'(ax) * (2*CW+2)'(ax);
      s1_sqy_r <= (2*CW+2)'(ay) * (2*CW+2)'(ay);
      s1_sb_r  <= {entry[EW-1], entry[31:0]};
    end
  end

  // Distance in Q.8 through the root pipeline.
  logic [SQW-1:0]  sqsum;
  logic [2*QW-1:0] rad;
  logic            d_vld;
  logic [QW-1:0]   dq;
  logic [SBW-1:0]  d_sb;

  assign sqsum = SQW'(s1_sqx_r) + SQW'(s1_sqy_r);
  assign rad   = (2*QW)'(sqsum) << adpb_pkg::RAD_SHIFT;

  adpb_isqrt #(.QW(QW), .SBW(SBW)) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s1_vld_r),
    .radicand  (rad),
    .in_sb     (s1_sb_r),
    .out_valid (d_vld),
    .root      (dq),
    .out_sb    (d_sb)
  );

  // Alpha products for the disc edge and the ring.
  logic [QW-1:0]  rq, diff, e;
  logic           in_zone;
  logic           s3_vld_r;
  logic [QW+8:0]  s3_pf_r;
  logic [16:0]    s3_pr_r;
  logic [SBW-1:0] s3_sb_r;

  assign rq      = QW'({radius, 8'd0});
  assign in_zone = d_sb[32];
  assign diff    = rq - dq;
  assign e       = (dq > rq) ? dq - rq : rq - dq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_pf_r <= (in_zone && (dq < rq)) ?
                 (QW+9)'(adpb_pkg::FILL_GAIN) * (QW+9)'(diff) : '0;
      s3_pr_r <= (in_zone && (e <= QW'(256))) ?
                 17'(adpb_pkg::RING_PEAK) * (17'd256 - 17'(e)) : '0;
      s3_sb_r <= d_sb;
    end
  end

  // Saturated fill alpha and ring alpha.
  logic           s4_vld_r;
  logic [7:0]     s4_fa_r, s4_ra_r;
  logic [SBW-1:0] s4_sb_r;
  logic [QW-1:0]  fa_raw;

  assign fa_raw = QW'(s3_pf_r >> adpb_pkg::FILL_SHIFT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_fa_r <= (fa_raw > QW'(255)) ? 8'd255 : fa_raw[7:0];
      s4_ra_r <= s3_pr_r[15:8];
      s4_sb_r <= s3_sb_r;
    end
  end

  // Fill blend products.
  logic        s5_vld_r;
  logic [15:0] s5_r_r, s5_g_r, s5_b_r;
  logic [7:0]  s5_a_r, s5_ra_r;
  logic [7:0]  ifa;

  assign ifa = 8'd255 - s4_fa_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (en) begin
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_r_r  <= 16'(fill_red) * 16'(s4_fa_r) + 16'(s4_sb_r[31:24]) * 16'(ifa);
      s5_g_r  <= 16'(fill_green) * 16'(s4_fa_r) + 16'(s4_sb_r[23:16]) * 16'(ifa);
      s5_b_r  <= 16'(fill_blue) * 16'(s4_fa_r) + 16'(s4_sb_r[15:8]) * 16'(ifa);
      s5_a_r  <= (s4_fa_r > s4_sb_r[7:0]) ? s4_fa_r : s4_sb_r[7:0];
      s5_ra_r <= s4_ra_r;
    end
  end

  // Fill blend division and the combined alpha.
  logic       s6_vld_r;
  logic [7:0] s6_r_r, s6_g_r, s6_b_r, s6_a_r, s6_ra_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else if (en) begin
      s6_vld_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_r_r  <= adpb_pkg::div255(s5_r_r);
      s6_g_r  <= adpb_pkg::div255(s5_g_r);
      s6_b_r  <= adpb_pkg::div255(s5_b_r);
      s6_a_r  <= (s5_ra_r > s5_a_r) ? s5_ra_r : s5_a_r;
      s6_ra_r <= s5_ra_r;
    end
  end

  // Ring blend products; the ring is black so only the kept part remains.
  logic        s7_vld_r;
  logic [15:0] s7_r_r, s7_g_r, s7_b_r;
  logic [7:0]  s7_a_r;
  logic [7:0]  ira;

  assign ira = 8'd255 - s6_ra_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_vld_r <= 1'b0;
    end else if (en) begin
      s7_vld_r <= s6_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_r_r <= 16'(s6_r_r) * 16'(ira);
      s7_g_r <= 16'(s6_g_r) * 16'(ira);
      s7_b_r <= 16'(s6_b_r) * 16'(ira);
      s7_a_r <= s6_a_r;
    end
  end

  // Output register.
  logic       out_vld_r;
  logic [7:0] out_r_r, out_g_r, out_b_r, out_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= s7_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r_r <= adpb_pkg::div255(s7_r_r);
      out_g_r <= adpb_pkg::div255(s7_g_r);
      out_b_r <= adpb_pkg::div255(s7_b_r);
      out_a_r <= s7_a_r;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.out_red   = out_r_r;
  assign out_ch.out_green = out_g_r;
  assign out_ch.out_blue  = out_b_r;
  assign out_ch.out_alpha = out_a_r;
endmodule

// ===== rtl/core/antialiased_dot_pixel_blender_top.sv =====
// Antialiased dot blender: each canvas pixel comes back with a soft-edged
// filled disc and a black outline ring composited over it. The block takes
// one pixel per clock and returns one per clock while the output is not
// stalled. Most of its pipeline depth is the square-root pipeline, which
// resolves one distance bit per stage. A four-entry queue after the input
// classifier and a register at the output let each side stall on its own.
// Configuration must be written through the cfg_ port only while no pixel is
// in flight; the block does not enforce this. Unknown indexes are ignored.
`include "antialiased_dot_pixel_blender_top_macros.svh"

module antialiased_dot_pixel_blender_top #(
  parameter int COORD_WIDTH = adpb_pkg::COORD_WIDTH_DEF,
  parameter int CFG_DW      = (COORD_WIDTH + 1 > 8) ? COORD_WIDTH + 1 : 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  adpb_in_if.sink                        in_ch,
  adpb_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [adpb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]              cfg_wdata
);
  localparam int CW = COORD_WIDTH;
  localparam int EW = 2 * (CW + 1) + 33;

  // Configuration registers.
  logic [CW-1:0] center_x_r, center_y_r;
  logic [CW-2:0] radius_r;
  logic [7:0]    fill_red_r, fill_green_r, fill_blue_r;
  logic [CW:0]   canvas_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r    <= '0;
      center_y_r    <= '0;
      radius_r      <= (CW-1)'(adpb_pkg::RADIUS_RESET);
      fill_red_r    <= '0;
      fill_green_r  <= '0;
      fill_blue_r   <= '0;
      canvas_size_r <= (CW+1)'(adpb_pkg::CANVAS_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        adpb_pkg::REG_CENTER_X:    center_x_r    <= cfg_wdata[CW-1:0];
        adpb_pkg::REG_CENTER_Y:    center_y_r    <= cfg_wdata[CW-1:0];
        adpb_pkg::REG_RADIUS:      radius_r      <= cfg_wdata[CW-2:0];
        adpb_pkg::REG_FILL_RED:    fill_red_r    <= cfg_wdata[7:0];
        adpb_pkg::REG_FILL_GREEN:  fill_green_r  <= cfg_wdata[7:0];
        adpb_pkg::REG_FILL_BLUE:   fill_blue_r   <= cfg_wdata[7:0];
        adpb_pkg::REG_CANVAS_SIZE: canvas_size_r <= cfg_wdata[CW:0];
        default: ;
      endcase
    end
  end

  // Front end: classify and queue.
  logic [EW-1:0]         f_entry, q_entry;
  logic                  q_push, q_pop;
  adpb_pkg::adpb_qstat_t q_stat;

  adpb_front #(.CW(CW), .EW(EW)) u_front (
    .px          (in_ch.pixel_x),
    .py          (in_ch.pixel_y),
    .rgba        ({in_ch.dst_red, in_ch.dst_green, in_ch.dst_blue, in_ch.dst_alpha}),
    .center_x    (center_x_r),
    .center_y    (center_y_r),
    .radius      (radius_r),
    .canvas_size (canvas_size_r),
    .entry       (f_entry)
  );

  assign in_ch.ready = !q_stat.full;
  assign q_push      = in_ch.valid && in_ch.ready;

  adpb_queue #(.EW(EW), .DEPTH(4)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (f_entry),
    .pop   (q_pop),
    .rdata (q_entry),
    .stat  (q_stat)
  );

  // Back end: distance, alphas and blending.
  adpb_back #(.CW(CW), .EW(EW)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .qstat      (q_stat),
    .entry      (q_entry),
    .pop        (q_pop),
    .radius     (radius_r),
    .fill_red   (fill_red_r),
    .fill_green (fill_green_r),
    .fill_blue  (fill_blue_r),
    .out_ch     (out_ch)
  );

  // The queue is never drained past empty nor written when full.
  `ADPB_ASSERT(a_pop_not_empty, q_pop |-> !q_stat.empty, "queue popped while empty")
  `ADPB_ASSERT(a_no_push_full, q_stat.full |-> !q_push, "queue written while full")
  // No result may appear in the cycle after reset.
  `ADPB_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !out_ch.valid, "result valid after reset")
endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import adpb_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int DW = (CW + 1 > 8) ? CW + 1 : 8;
  localparam int LATENCY = CW + 17;

  typedef struct packed {
    logic [CW-1:0] px;
    logic [CW-1:0] py;
    logic [7:0]    r;
    logic [7:0]    g;
    logic [7:0]    b;
    logic [7:0]    a;
  } pixel_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } rgba_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DW-1:0] cfg_wdata;

  adpb_in_if #(.CW(CW)) in_ch ();
  adpb_out_if out_ch ();

  antialiased_dot_pixel_blender_top #(.COORD_WIDTH(CW)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the disc settings.
  logic [CW-1:0] ctr_x, ctr_y;
  logic [CW-2:0] rad;
  logic [7:0]    fill_r, fill_g, fill_b;
  logic [CW:0]   canvas;

  rgba_t expected_pixels[$];
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_cycles;
  int mismatches;
  int results_seen;
  int pixels_sent;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [7:0] mix(input int s, input int c, input int al);
    return 8'((s * al + c * (255 - al)) / 255);
  endfunction

  // Composite the fill disc and the outline ring over one pixel.
  function automatic rgba_t composite_pixel(input pixel_t p);
    rgba_t o;
    int ex, ey, lim, ox, oy, fa, ra;
    longint dq, rq, e, t;
    o = '{p.r, p.g, p.b, p.a};
    ex = int'(p.px) - int'(ctr_x);
    ey = int'(p.py) - int'(ctr_y);
    lim = int'(rad) + 2;
    if (p.px < canvas && p.py < canvas && ex >= -lim && ex <= lim &&
        ey >= -lim && ey <= lim) begin
      ox = 2 * ex + 1;
      oy = 2 * ey + 1;
      dq = root_floor(longint'(ox * ox + oy * oy) * 16384);
      rq = longint'(rad) * 256;
      fa = 0;
      ra = 0;
      if (dq < rq) begin
        t = (1275 * (rq - dq)) / 1536;
        fa = t > 255 ? 255 : int'(t);
      end
      if (fa != 0) begin
        o.r = mix(fill_r, o.r, fa);
        o.g = mix(fill_g, o.g, fa);
        o.b = mix(fill_b, o.b, fa);
        if (fa > o.a) o.a = 8'(fa);
      end
      e = dq > rq ? dq - rq : rq - dq;
      if (e <= 256) ra = int'((150 * (256 - e)) / 256);
      if (ra != 0) begin
        o.r = mix(0, o.r, ra);
        o.g = mix(0, o.g, ra);
        o.b = mix(0, o.b, ra);
        if (ra > o.a) o.a = 8'(ra);
      end
    end
    return o;
  endfunction

  // Send one pixel and record its expected composite; valid stays high
  // after acceptance so that the next transaction can follow directly.
  task automatic send_pixel(input pixel_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.pixel_x   <= p.px;
    in_ch.pixel_y   <= p.py;
    in_ch.dst_red   <= p.r;
    in_ch.dst_green <= p.g;
    in_ch.dst_blue  <= p.b;
    in_ch.dst_alpha <= p.a;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_pixels.push_back(composite_pixel(p));
    pixels_sent++;
  endtask

  // Stop sending and wait until every result is back.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= DW'(val);
    @(posedge clk);
    case (idx)
      REG_CENTER_X:    ctr_x = CW'(val);
      REG_CENTER_Y:    ctr_y = CW'(val);
      REG_RADIUS:      rad = (CW-1)'(val);
      REG_FILL_RED:    fill_r = 8'(val);
      REG_FILL_GREEN:  fill_g = 8'(val);
      REG_FILL_BLUE:   fill_b = 8'(val);
      REG_CANVAS_SIZE: canvas = (CW+1)'(val);
      default: ;
    endcase
  endtask

  task automatic set_disc(input int cx, input int cy, input int r, input int cs);
    wait_drained();
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_RADIUS, r);
    write_reg(REG_FILL_RED, $urandom_range(255));
    write_reg(REG_FILL_GREEN, $urandom_range(255));
    write_reg(REG_FILL_BLUE, $urandom_range(255));
    write_reg(REG_CANVAS_SIZE, cs);
    cfg_we <= 1'b0;
  endtask

  // A pixel near the disc most of the time, anywhere otherwise.
  function automatic pixel_t pick_pixel();
    pixel_t p;
    int lim;
    p = {CW'($urandom), CW'($urandom), $urandom};
    lim = int'(rad) + 3;
    if ($urandom_range(9) < 8) begin
      p.px = CW'(int'(ctr_x) + $urandom_range(2 * lim) - lim);
      p.py = CW'(int'(ctr_y) + $urandom_range(2 * lim) - lim);
    end
    return p;
  endfunction

  // Receiver: random stalls plus an optional long hold-off.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_off_cycles--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      rgba_t want;
      results_seen++;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transaction");
      end else begin
        want = expected_pixels.pop_front();
        if (want.r !== out_ch.out_red || want.g !== out_ch.out_green ||
            want.b !== out_ch.out_blue || want.a !== out_ch.out_alpha) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected rgba %h %h %h %h, got %h %h %h %h",
                     want.r, want.g, want.b, want.a, out_ch.out_red,
                     out_ch.out_green, out_ch.out_blue, out_ch.out_alpha);
        end
      end
    end
  end

  // Extremes, special cases and the reset settings.
  task automatic test_directed();
    pixel_t p;
    // Reset settings: disc at the origin, radius 6, canvas 64.
    p = '{0, 0, 8'hff, 8'h00, 8'hff, 8'h00}; send_pixel(p);
    p = '{6, 0, 8'h00, 8'hff, 8'h00, 8'hff}; send_pixel(p);
    p = '{9, 9, 8'h55, 8'haa, 8'h55, 8'haa}; send_pixel(p);
    set_disc(500, 500, 10, 1024);
    p = '{500, 500, 8'h00, 8'h00, 8'h00, 8'h00}; send_pixel(p);
    p = '{510, 500, 8'hff, 8'hff, 8'hff, 8'hff}; send_pixel(p);
    p = '{511, 503, 8'h12, 8'h34, 8'h56, 8'h78}; send_pixel(p);
    p = '{513, 500, 8'h80, 8'h80, 8'h80, 8'h80}; send_pixel(p);
    p = '{487, 488, 8'h01, 8'h02, 8'h03, 8'h04}; send_pixel(p);
    p = '{1023, 1023, 8'hff, 8'hff, 8'hff, 8'hff}; send_pixel(p);
    // Zero radius: only the ring close to the centre.
    set_disc(1023, 1023, 0, 1024);
    p = '{1023, 1023, 8'hc0, 8'hc0, 8'hc0, 8'h10}; send_pixel(p);
    p = '{1022, 1022, 8'hc0, 8'hc0, 8'hc0, 8'h10}; send_pixel(p);
    p = '{1021, 1023, 8'hc0, 8'hc0, 8'hc0, 8'h10}; send_pixel(p);
    // Largest radius, smallest canvas, outside canvas.
    set_disc(0, 0, 511, 1);
    p = '{0, 0, 8'h40, 8'h40, 8'h40, 8'h40}; send_pixel(p);
    p = '{1, 0, 8'h40, 8'h40, 8'h40, 8'h40}; send_pixel(p);
    p = '{0, 1, 8'h40, 8'h40, 8'h40, 8'h40}; send_pixel(p);
    // Canvas size zero passes everything through.
    set_disc(5, 5, 3, 0);
    p = '{5, 5, 8'h40, 8'h40, 8'h40, 8'h40}; send_pixel(p);
    set_disc(0, 1023, 511, 1024);
    p = '{511, 512, 8'h99, 8'h99, 8'h99, 8'h00}; send_pixel(p);
    p = '{300, 700, 8'h99, 8'h99, 8'h99, 8'h00}; send_pixel(p);
    wait_drained();
  endtask

  // Random pixels over several disc settings and idling profiles.
  task automatic test_random();
    int profile[4][2] = '{'{0, 0}, '{61, 0}, '{0, 61}, '{23, 23}};
    for (int ph = 0; ph < 16; ph++) begin
      send_idle_pct  = profile[ph % 4][0];
      recv_stall_pct = profile[ph % 4][1];
      if (ph % 5 == 4)
        set_disc($urandom_range(1023), $urandom_range(1023), $urandom_range(511),
                 $urandom_range(1024));
      else
        set_disc($urandom_range(1023), $urandom_range(1023), $urandom_range(1, 20),
                 $urandom_range(1) ? 1024 : $urandom_range(1, 1024));
      repeat (45) send_pixel(pick_pixel());
    end
    wait_drained();
  endtask

  // Long receiver hold-off while pixels keep coming, so the input backs up.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_disc(100, 100, 8, 1024);
    hold_off_cycles = 200;
    repeat (60) send_pixel(pick_pixel());
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.pixel_x = '0;
    in_ch.pixel_y = '0;
    in_ch.dst_red = '0;
    in_ch.dst_green = '0;
    in_ch.dst_blue = '0;
    in_ch.dst_alpha = '0;
    ctr_x = 0; ctr_y = 0; rad = RADIUS_RESET;
    fill_r = 0; fill_g = 0; fill_b = 0; canvas = CANVAS_RESET;
    send_idle_pct = 0; recv_stall_pct = 0; hold_off_cycles = 0;
    mismatches = 0; results_seen = 0; pixels_sent = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    test_backpressure();
    $display("Sent %0d pixels over fill, ring, clipping and stall cases;", pixels_sent);
    $display("checked %0d results, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
